[rtl/core/assert_macros.svh]
// Assertion macros shared by the checker files.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

[rtl/core/tdm_pkg.sv]
// Package for the time demultiplexer: default sizes, word type, bus width.
// No dependencies.
package tdm_pkg;

   localparam int NUM_LINKS_DEF  = 3;
   localparam int BLOCK_SIZE_DEF = 64;
   localparam int PAGE_SIZE_DEF  = 192;

   localparam int DATA_W = 64;
   localparam int WORD_W = DATA_W + 1;

   // bit 0: valid flag, bits 64..1: data
   typedef logic [WORD_W-1:0] word_type;

   // out_valid/new_event bit plus one word per link, padded to whole bytes
   function automatic int bus_width(input int links);
      return ((1 + links * WORD_W + 7) / 8) * 8;
   endfunction

endpackage

[rtl/core/time_demultiplexer_core.sv]
// Top level of the time demultiplexer: sequencer, link banks, output stage.
// Depends on tdm_pkg, tdm_ctrl, tdm_bank, tdm_out.
//
// Channel  Dir  Ports                         Payload (tdata, low bit first)
// req      in   req_tvalid/tready/tdata       new_event, {linkK_valid, linkK_data} K=0..N-1
// rsp      out  rsp_tvalid/tready/tdata       out_valid, {laneK_valid, laneK_data} K=0..N-1
//
// One transaction per cycle sustained unless the response stalls; a response is registered
// first by the registered bank read and then by the response register.
// req_tready = !rsp_tvalid || rsp_tready; a stalled response freezes the read stage.
// Synchronous active-high reset clears control state only; banks are not cleared.
// The first read transaction follows new_event by (NUM_LINKS-1)*BLOCK_SIZE+1 transactions.
module time_demultiplexer_core #(
   parameter int  NUM_LINKS  = tdm_pkg::NUM_LINKS_DEF,
   parameter int  BLOCK_SIZE = tdm_pkg::BLOCK_SIZE_DEF,
   parameter int  PAGE_SIZE  = tdm_pkg::PAGE_SIZE_DEF,
   localparam int BusW       = tdm_pkg::bus_width(NUM_LINKS)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   // new_event, link0_valid, link0_data, link1_valid, link1_data, ...
   input  logic [BusW-1:0] req_tdata,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   // out_valid, lane0_valid, lane0_data, lane1_valid, lane1_data, ...
   output logic [BusW-1:0] rsp_tdata
);
   import tdm_pkg::*;

   localparam int MemDepth = 2 * PAGE_SIZE;
   localparam int AddrW    = $clog2(MemDepth);
   localparam int RotW     = $clog2(NUM_LINKS);

   logic                             accept;
   logic                             adv;
   logic [NUM_LINKS-1:0][AddrW-1:0]  wr_addr;
   logic [NUM_LINKS-1:0][RotW-1:0]   wr_link;
   logic [AddrW-1:0]                 rd_addr;
   logic                             rd_on;
   logic [RotW-1:0]                  rd_rot;
   logic [NUM_LINKS-1:0][WORD_W-1:0] link_word;
   logic [NUM_LINKS-1:0][WORD_W-1:0] bank_data;

   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   for (genvar k = 0; k < NUM_LINKS; k++) begin : g_link
      assign link_word[k] = req_tdata[1 + k * WORD_W +: WORD_W];
   end

   tdm_ctrl #(
      .NUM_LINKS  (NUM_LINKS),
      .BLOCK_SIZE (BLOCK_SIZE),
      .PAGE_SIZE  (PAGE_SIZE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .new_event (req_tdata[0]),
      .wr_addr   (wr_addr),
      .wr_link   (wr_link),
      .rd_addr   (rd_addr),
      .rd_on     (rd_on),
      .rd_rot    (rd_rot)
   );

   for (genvar m = 0; m < NUM_LINKS; m++) begin : g_bank
      tdm_bank #(
         .DEPTH (MemDepth)
      ) u_bank (
         .clock   (clock),
         .wr_en   (accept),
         .wr_addr (wr_addr[m]),
         .wr_data (link_word[wr_link[m]]),
         .rd_en   (adv),
         .rd_addr (rd_addr),
         .rd_data (bank_data[m])
      );
   end

   tdm_out #(
      .NUM_LINKS (NUM_LINKS)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rd_on      (rd_on),
      .rd_rot     (rd_rot),
      .bank_data  (bank_data),
      .rsp_tready (rsp_tready),
      .adv        (adv),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[rtl/core/tdm_bank.sv]
// One link memory (two pages) with one write and one registered read port.
// Same-cycle write to the read address is forwarded. Depends on tdm_pkg.
module tdm_bank #(
   parameter int  DEPTH = 2 * tdm_pkg::PAGE_SIZE_DEF,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AddrW-1:0]  wr_addr,
   input  tdm_pkg::word_type wr_data,
   input  logic              rd_en,
   input  logic [AddrW-1:0]  rd_addr,
   output tdm_pkg::word_type rd_data
);
   import tdm_pkg::*;

   word_type store_ff [DEPTH];
   word_type rd_data_ff;
   logic     fwd;

   assign fwd = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= fwd ? wr_data : store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/tdm_ctrl.sv]
// Write/read sequencer: block counters, page flags, write offsets, read pointer.
// Produces per-bank write addresses and link selects. Depends on tdm_pkg.
module tdm_ctrl #(
   parameter int  NUM_LINKS  = tdm_pkg::NUM_LINKS_DEF,
   parameter int  BLOCK_SIZE = tdm_pkg::BLOCK_SIZE_DEF,
   parameter int  PAGE_SIZE  = tdm_pkg::PAGE_SIZE_DEF,
   localparam int AddrW      = $clog2(2 * PAGE_SIZE),
   localparam int RotW       = $clog2(NUM_LINKS)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic                             new_event,
   output logic [NUM_LINKS-1:0][AddrW-1:0]  wr_addr,
   output logic [NUM_LINKS-1:0][RotW-1:0]   wr_link,
   output logic [AddrW-1:0]                 rd_addr,
   output logic                             rd_on,
   output logic [RotW-1:0]                  rd_rot
);
   import tdm_pkg::*;

   localparam int MemDepth = 2 * PAGE_SIZE;
   localparam int PosW     = $clog2(BLOCK_SIZE);

   logic [PosW-1:0]                  pos_ff, pos_in;
   logic [RotW-1:0]                  blk_ff, blk_in;
   logic [RotW-1:0]                  wrot_ff, wrot_in;
   logic [NUM_LINKS-1:0]             page_ff, page_in;
   logic [NUM_LINKS-1:0][AddrW-1:0]  off_ff, off_in;
   logic                             reading_ff, reading_in;
   logic [AddrW-1:0]                 raddr_ff, raddr_in;
   logic [RotW-1:0]                  rrot_ff, rrot_in;
   logic [PosW-1:0]                  rcnt_ff, rcnt_in;

   logic [NUM_LINKS-1:0][AddrW-1:0]  base_lo, base_hi;

   for (genvar g = 0; g < NUM_LINKS; g++) begin : g_base
      localparam int BaseLo = (g * BLOCK_SIZE) % MemDepth;
      localparam int BaseHi = (BaseLo + PAGE_SIZE) % MemDepth;
      assign base_lo[g] = AddrW'(BaseLo);
      assign base_hi[g] = AddrW'(BaseHi);
   end

   always_comb begin
      logic [PosW-1:0]                 pos_e;
      logic [RotW-1:0]                 blk_e;
      logic [RotW-1:0]                 wrot_e;
      logic [NUM_LINKS-1:0]            page_e;
      logic [NUM_LINKS-1:0][AddrW-1:0] off_e;
      logic                            reading_e;
      logic                            last_pos;
      logic [RotW:0]                   lnk_w;
      logic [RotW-1:0]                 lnk;

      pos_e     = new_event ? '0 : pos_ff;
      blk_e     = new_event ? '0 : blk_ff;
      wrot_e    = new_event ? '0 : wrot_ff;
      reading_e = new_event ? 1'b0 : reading_ff;
      for (int i = 0; i < NUM_LINKS; i++) begin
         page_e[i] = new_event ? (i == 0) : page_ff[i];
         off_e[i]  = new_event ? ((i == 0) ? base_hi[i] : base_lo[i]) : off_ff[i];
      end

      // bank m takes the link that the rotation maps onto it
      for (int m = 0; m < NUM_LINKS; m++) begin
         if (RotW'(m) >= wrot_e) begin
            lnk_w = (RotW + 1)'(m) - {1'b0, wrot_e};
         end else begin
            lnk_w = (RotW + 1)'(m + NUM_LINKS) - {1'b0, wrot_e};
         end
         lnk        = lnk_w[RotW-1:0];
         wr_link[m] = lnk;
         wr_addr[m] = off_e[lnk];
      end

      wrot_in  = (wrot_e == RotW'(NUM_LINKS - 1)) ? '0 : wrot_e + 1'b1;
      last_pos = (pos_e == PosW'(BLOCK_SIZE - 1));
      pos_in   = last_pos ? '0 : pos_e + 1'b1;
      if (last_pos) begin
         blk_in = (blk_e == RotW'(NUM_LINKS - 1)) ? '0 : blk_e + 1'b1;
      end else begin
         blk_in = blk_e;
      end

      page_in = page_e;
      off_in  = off_e;
      if (wrot_in == '0) begin
         for (int i = 0; i < NUM_LINKS; i++) begin
            off_in[i] = (off_e[i] == AddrW'(MemDepth - 1)) ? '0 : off_e[i] + 1'b1;
         end
         // completed link flips page and restarts at its block base
         if (pos_in == '0) begin
            page_in[blk_in] = ~page_e[blk_in];
            off_in[blk_in]  = page_in[blk_in] ? base_hi[blk_in] : base_lo[blk_in];
         end
      end

      reading_in = reading_e;
      raddr_in   = raddr_ff;
      rrot_in    = rrot_ff;
      rcnt_in    = rcnt_ff;
      rd_on      = reading_e;
      if (!reading_e) begin
         if ((blk_in == RotW'(NUM_LINKS - 1)) && (pos_in == PosW'(1))) begin
            reading_in = 1'b1;
            raddr_in   = AddrW'(PAGE_SIZE);
            rrot_in    = '0;
            rcnt_in    = '0;
         end
      end else begin
         raddr_in = (raddr_ff == AddrW'(MemDepth - 1)) ? '0 : raddr_ff + 1'b1;
         rcnt_in  = (rcnt_ff == PosW'(BLOCK_SIZE - 1)) ? '0 : rcnt_ff + 1'b1;
         if (rcnt_in == '0) begin
            rrot_in = (rrot_ff == RotW'(NUM_LINKS - 1)) ? '0 : rrot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         blk_ff     <= '0;
         wrot_ff    <= '0;
         page_ff    <= '0;
         off_ff     <= '0;
         reading_ff <= 1'b0;
         raddr_ff   <= '0;
         rrot_ff    <= '0;
         rcnt_ff    <= '0;
      end else if (accept) begin
         pos_ff     <= pos_in;
         blk_ff     <= blk_in;
         wrot_ff    <= wrot_in;
         page_ff    <= page_in;
         off_ff     <= off_in;
         reading_ff <= reading_in;
         raddr_ff   <= raddr_in;
         rrot_ff    <= rrot_in;
         rcnt_ff    <= rcnt_in;
      end
   end

   assign rd_addr = raddr_ff;
   assign rd_rot  = rrot_ff;

endmodule

[rtl/core/tdm_out.sv]
// Output side: read stage control, lane rotation and the response register.
// Depends on tdm_pkg.
module tdm_out #(
   parameter int  NUM_LINKS = tdm_pkg::NUM_LINKS_DEF,
   localparam int RotW      = $clog2(NUM_LINKS),
   localparam int BusW      = tdm_pkg::bus_width(NUM_LINKS)
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      accept,
   input  logic                                      rd_on,
   input  logic [RotW-1:0]                           rd_rot,
   input  logic [NUM_LINKS-1:0][tdm_pkg::WORD_W-1:0] bank_data,
   input  logic                                      rsp_tready,
   output logic                                      adv,
   output logic                                      rsp_tvalid,
   output logic [BusW-1:0]                           rsp_tdata
);
   import tdm_pkg::*;

   logic            s1_valid_ff;
   logic            s1_on_ff;
   logic [RotW-1:0] s1_rot_ff;
   logic            rsp_valid_ff;
   logic [BusW-1:0] rsp_data_ff, rsp_data_in;

   assign adv = !rsp_valid_ff || rsp_tready;

   always_comb begin
      logic [RotW:0]   sum;
      logic [RotW-1:0] sel;

      sum         = '0;
      sel         = '0;
      rsp_data_in = '0;
      if (s1_on_ff) begin
         rsp_data_in[0] = 1'b1;
         for (int i = 0; i < NUM_LINKS; i++) begin
            sum = {1'b0, s1_rot_ff} + (RotW + 1)'(i);
            if (sum >= (RotW + 1)'(NUM_LINKS)) begin
               sum = sum - (RotW + 1)'(NUM_LINKS);
            end
            sel = sum[RotW-1:0];
            rsp_data_in[1 + i * WORD_W +: WORD_W] = bank_data[sel];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= accept;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_on_ff    <= rd_on;
         s1_rot_ff   <= rd_rot;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/core/tdm_checker.sv]
// Port-level assertions for time_demultiplexer_core, attached by bind.
// Depends on tdm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tdm_checker #(
   parameter int  NUM_LINKS = tdm_pkg::NUM_LINKS_DEF,
   localparam int BusW      = tdm_pkg::bus_width(NUM_LINKS)
) (
   input logic            clock,
   input logic            reset,
   input logic            req_tvalid,
   input logic            req_tready,
   input logic [BusW-1:0] req_tdata,
   input logic            rsp_tvalid,
   input logic            rsp_tready,
   input logic [BusW-1:0] rsp_tdata
);
   import tdm_pkg::*;

   `ASSERT_PROP(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp transaction changed while stalled")

   `ASSERT_NEVER(a_ready_when_empty, !rsp_tvalid && !req_tready, "req not ready with empty output")

   `ASSERT_PROP(a_idle_zero, rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata == '0, "lanes not zero while out_valid low")

   `ASSERT_PROP(a_event_quiet, req_tvalid && req_tready && req_tdata[0] ##1 (rsp_tready || !rsp_tvalid) |=> rsp_tvalid && !rsp_tdata[0], "new_event transaction produced a read")

endmodule

bind time_demultiplexer_core tdm_checker #(.NUM_LINKS(NUM_LINKS)) u_tdm_checker (.*);

[tb/time_demultiplexer_core_tb.sv]
// Self-checking testbench for time_demultiplexer_core: drives link transactions,
// predicts every lane word and checks each response transaction.
// Depends on tdm_pkg and the time_demultiplexer_core RTL.
`timescale 1ns / 100ps

module time_demultiplexer_core_tb;
   import tdm_pkg::*;

   localparam int NL    = NUM_LINKS_DEF;
   localparam int BS    = BLOCK_SIZE_DEF;
   localparam int PS    = PAGE_SIZE_DEF;
   localparam int DEPTH = 2 * PS;
   localparam int FRAME = NL * BS;
   localparam int BUS_W = bus_width(NL);
   localparam int LIMIT = 200000;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              valid;
   } link_word_type;

   typedef struct {
      logic          new_event;
      link_word_type word[NL];
   } link_item_type;

   typedef struct {
      logic          out_valid;
      link_word_type lane[NL];
   } lane_result_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [BUS_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [BUS_W-1:0] rsp_tdata;

   time_demultiplexer_core #(
      .NUM_LINKS (NL),
      .BLOCK_SIZE(BS),
      .PAGE_SIZE (PS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // predictor state
   bit [7:0]      frame_pos;
   bit [1:0]      wr_rot;
   bit [NL-1:0]   page_sel;
   bit [8:0]      wr_ptr[NL];
   bit            rd_active;
   bit [8:0]      rd_ptr;
   bit [1:0]      rd_rot;
   bit [5:0]      rd_run;
   link_word_type bank[NL][DEPTH];
   bit            bank_written[NL][DEPTH];

   lane_result_type expected_lanes[$];
   int              fault_count;
   int              send_idle_pct;
   int              stall_pct;
   int              hold_cycles;
   int              cycle_total;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit [8:0] link_base(input int link);
      return 9'((link * BS + (page_sel[link] ? PS : 0)) % DEPTH);
   endfunction

   function automatic lane_result_type demux_predict(input link_item_type it);
      lane_result_type r;
      int unsigned     mem;
      int unsigned     done;
      if (it.new_event) begin
         frame_pos = '0;
         wr_rot    = '0;
         for (int i = 0; i < NL; i++) begin
            page_sel[i] = (i == 0);
            wr_ptr[i]   = link_base(i);
         end
         rd_active = 1'b0;
      end
      for (int i = 0; i < NL; i++) begin
         mem = (wr_rot + i) % NL;
         bank[mem][wr_ptr[i]]         = it.word[i];
         bank_written[mem][wr_ptr[i]] = 1'b1;
      end
      wr_rot    = 2'((wr_rot + 1) % NL);
      frame_pos = 8'((frame_pos + 1) % FRAME);
      if (wr_rot == 0) begin
         if (frame_pos % BS == 0) begin
            done = (frame_pos / BS) % NL;
            page_sel[done] = ~page_sel[done];
            for (int i = 0; i < NL; i++)
               wr_ptr[i] = (i == done) ? link_base(i) : 9'((wr_ptr[i] + 1) % DEPTH);
         end else begin
            for (int i = 0; i < NL; i++)
               wr_ptr[i] = 9'((wr_ptr[i] + 1) % DEPTH);
         end
      end
      if (!rd_active) begin
         if (frame_pos == (NL - 1) * BS + 1) begin
            rd_active = 1'b1;
            rd_ptr    = 9'(PS % DEPTH);
            rd_rot    = '0;
            rd_run    = '0;
         end
         r.out_valid = 1'b0;
         for (int i = 0; i < NL; i++)
            r.lane[i] = '0;
         return r;
      end
      r.out_valid = 1'b1;
      for (int i = 0; i < NL; i++)
         r.lane[i] = bank[(i + rd_rot) % NL][rd_ptr];
      rd_ptr = 9'((rd_ptr + 1) % DEPTH);
      rd_run = 6'((rd_run + 1) % BS);
      if (rd_run == 0)
         rd_rot = 2'((rd_rot + 1) % NL);
      return r;
   endfunction

   // true when this transaction would read a bank word never written since reset
   function automatic bit read_hits_unwritten(input link_item_type it);
      int unsigned mem;
      bit          filled;
      if (it.new_event || !rd_active)
         return 1'b0;
      for (int i = 0; i < NL; i++) begin
         mem    = (i + rd_rot) % NL;
         filled = bank_written[mem][rd_ptr];
         for (int j = 0; j < NL; j++)
            if ((wr_rot + j) % NL == mem && wr_ptr[j] == rd_ptr)
               filled = 1'b1;
         if (!filled)
            return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [BUS_W-1:0] pack_item(input link_item_type it);
      logic [BUS_W-1:0] v;
      v    = '0;
      v[0] = it.new_event;
      for (int i = 0; i < NL; i++)
         v[1 + i * WORD_W +: WORD_W] = it.word[i];
      return v;
   endfunction

   function automatic link_item_type pattern_item(input logic ev, input logic v,
                                                  input logic [DATA_W-1:0] d);
      link_item_type it;
      it.new_event = ev;
      for (int i = 0; i < NL; i++) begin
         it.word[i].valid = v;
         it.word[i].data  = d;
      end
      return it;
   endfunction

   function automatic link_item_type random_item();
      link_item_type it;
      it.new_event = ($urandom_range(299) == 0);
      for (int i = 0; i < NL; i++) begin
         it.word[i].valid = 1'($urandom_range(1));
         case ($urandom_range(7))
            0:       it.word[i].data = '0;
            1:       it.word[i].data = '1;
            default: it.word[i].data = {$urandom, $urandom};
         endcase
      end
      return it;
   endfunction

   task automatic send_item(input link_item_type it);
      if (!it.new_event && read_hits_unwritten(it))
         it.new_event = 1'b1;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pack_item(it);
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      expected_lanes.push_back(demux_predict(it));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_lanes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_random(input int n, input int idle, input int stall);
      send_idle_pct = idle;
      stall_pct     = stall;
      repeat (n) send_item(random_item());
      wait_drained();
   endtask

   task automatic test_directed();
      link_item_type it;
      send_idle_pct = 0;
      stall_pct     = 0;
      send_item(pattern_item(1'b0, 1'b0, '0));
      send_item(pattern_item(1'b0, 1'b1, '1));
      send_item(pattern_item(1'b1, 1'b1, '1));
      send_item(pattern_item(1'b0, 1'b0, '0));
      send_item(pattern_item(1'b0, 1'b1, 64'h5555_5555_5555_5555));
      send_item(pattern_item(1'b0, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA));
      send_item(pattern_item(1'b1, 1'b0, 64'h8000_0000_0000_0001));
      send_item(pattern_item(1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE));
      for (int k = 0; k < 6; k++) begin
         it = random_item();
         it.new_event = 1'b0;
         send_item(it);
      end
      wait_drained();
   endtask

   task automatic test_streaming();
      run_random(390, 0, 0);
   endtask

   task automatic test_sender_idle();
      run_random(390, 74, 0);
   endtask

   task automatic test_receiver_stall();
      run_random(390, 0, 74);
   endtask

   task automatic test_both_idle();
      run_random(390, 35, 35);
   endtask

   task automatic test_backpressure();
      hold_cycles = 80;
      run_random(150, 0, 0);
      hold_cycles = 120;
      run_random(240, 0, 20);
   endtask

   // response side ready/stall
   initial begin
      rsp_tready  = 1'b0;
      hold_cycles = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      lane_result_type seen;
      lane_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.out_valid = rsp_tdata[0];
         for (int i = 0; i < NL; i++)
            seen.lane[i] = rsp_tdata[1 + i * WORD_W +: WORD_W];
         if (expected_lanes.size() == 0) begin
            $error("rsp transaction with no expected result");
            fault_count++;
         end else begin
            want = expected_lanes.pop_front();
            if (seen.out_valid !== want.out_valid) begin
               $error("out_valid expected %h actual %h", want.out_valid, seen.out_valid);
               fault_count++;
            end
            for (int i = 0; i < NL; i++) begin
               if (seen.lane[i].valid !== want.lane[i].valid) begin
                  $error("lane%0d_valid expected %h actual %h", i,
                         want.lane[i].valid, seen.lane[i].valid);
                  fault_count++;
               end
               if (seen.lane[i].data !== want.lane[i].data) begin
                  $error("lane%0d_data expected %h actual %h", i,
                         want.lane[i].data, seen.lane[i].data);
                  fault_count++;
               end
            end
         end
      end
   end

   initial begin
      cycle_total = 0;
      while (cycle_total < LIMIT) begin
         @(posedge clock);
         cycle_total++;
      end
      $display("time_demultiplexer_core: mismatch");
      $finish;
   end

   initial begin
      fault_count   = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_streaming();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_backpressure();
      repeat (10) @(posedge clock);
      if (expected_lanes.size() != 0) begin
         $error("%0d expected results never arrived", expected_lanes.size());
         fault_count++;
      end
      if (fault_count == 0)
         $display("time_demultiplexer_core: match");
      else
         $display("time_demultiplexer_core: mismatch");
      $finish;
   end

endmodule

[time_demultiplexer_core.f]
+incdir+rtl/core
rtl/core/tdm_pkg.sv
rtl/core/tdm_bank.sv
rtl/core/tdm_ctrl.sv
rtl/core/tdm_out.sv
rtl/core/time_demultiplexer_core.sv
rtl/core/tdm_checker.sv
tb/time_demultiplexer_core_tb.sv
